// ===== hdl/mdds_pkg.sv =====
// mdds_pkg: shared types and constants of the multi-axis dds step generator
// no dependencies; compile first

package mdds_pkg;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_TARGET = 2'd1,
    CMD_STOP_ALL   = 2'd2,
    CMD_QUERY      = 2'd3
  } cmd_t;

  // width of the pin fields in a result transaction
  localparam int PIN_W = 3;

  typedef logic [PIN_W-1:0] pins_t;
  typedef logic [31:0]      word_t;
  typedef logic [7:0]       ticks_t;

  // configuration register indexes, byte address is 4 * index
  localparam int         CFG_ADDR_W     = 5;
  localparam logic [2:0] REG_DIR_INVERT = 3'd0;
  localparam logic [2:0] REG_STEP_LOW   = 3'd1;
  localparam logic [2:0] REG_DIR_HOLD   = 3'd2;
  localparam logic [2:0] REG_DIR_SETUP  = 3'd3;
  localparam logic [2:0] REG_ACT_HIGH   = 3'd4;

endpackage

// ===== hdl/mdds_if.sv =====
// mdds_in_if / mdds_out_if: valid-ready channels for commands and results
// depends on mdds_pkg

interface mdds_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [1:0]         axis;
  logic signed [31:0] target;
  logic [31:0]        rate_increment;

  modport source (output valid, cmd, axis, target, rate_increment, input ready);
  modport sink   (input valid, cmd, axis, target, rate_increment, output ready);
endinterface

interface mdds_out_if;
  logic                 valid;
  logic                 ready;
  mdds_pkg::pins_t      step_pins;
  mdds_pkg::pins_t      dir_pins;
  logic signed [31:0]   position;
  logic                 busy_res;

  modport source (output valid, step_pins, dir_pins, position, busy_res, input ready);
  modport sink   (input valid, step_pins, dir_pins, position, busy_res, output ready);
endinterface

// ===== hdl/multi_axis_dds_step_generator_top.sv =====
// multi_axis_dds_step_generator_top: per-axis dds phase accumulators driving step/dir pins
// depends on mdds_pkg and the channel interfaces in mdds_if.sv
// a command waits in the input register and its result in the result register
// one command per cycle unless results stall; all axes update at once in the result stage
// the result register lets a new command enter while a finished result waits
// rst_n (synchronous, active low) clears all axis state, pins and pipeline valids,
// and sets the configuration registers to their defaults

module multi_axis_dds_step_generator_top #(
  parameter int AXIS_COUNT = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mdds_in_if.sink                             in_ch,
  mdds_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [mdds_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import mdds_pkg::*;

  localparam int ExtCount = (AXIS_COUNT > PIN_W) ? AXIS_COUNT : PIN_W;

  // configuration
  pins_t  dir_inv_r;
  ticks_t step_low_r;
  ticks_t dir_hold_r;
  ticks_t dir_setup_r;
  logic   act_high_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_inv_r   <= '0;
      step_low_r  <= 8'd1;
      dir_hold_r  <= 8'd1;
      dir_setup_r <= 8'd1;
      act_high_r  <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DIR_INVERT: dir_inv_r   <= cfg_pwdata[PIN_W-1:0];
        REG_STEP_LOW:   step_low_r  <= cfg_pwdata[7:0];
        REG_DIR_HOLD:   dir_hold_r  <= cfg_pwdata[7:0];
        REG_DIR_SETUP:  dir_setup_r <= cfg_pwdata[7:0];
        REG_ACT_HIGH:   act_high_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DIR_INVERT: cfg_prdata = {{(32-PIN_W){1'b0}}, dir_inv_r};
      REG_STEP_LOW:   cfg_prdata = {24'd0, step_low_r};
      REG_DIR_HOLD:   cfg_prdata = {24'd0, dir_hold_r};
      REG_DIR_SETUP:  cfg_prdata = {24'd0, dir_setup_r};
      REG_ACT_HIGH:   cfg_prdata = {31'd0, act_high_r};
      default:        cfg_prdata = '0;
    endcase
  end

  // input register
  logic        s1_valid_r;
  cmd_t        s1_cmd_r;
  logic [1:0]  s1_axis_r;
  word_t       s1_target_r;
  word_t       s1_inc_r;
  logic        advance;
  logic        in_acc;

  // result register
  logic        out_valid_r;
  pins_t       out_step_r;
  pins_t       out_dir_r;
  word_t       out_pos_r;
  logic        out_busy_r;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= cmd_t'(in_ch.cmd);
      s1_axis_r   <= in_ch.axis;
      s1_target_r <= word_t'(in_ch.target);
      s1_inc_r    <= in_ch.rate_increment;
    end
  end

  // axis state
  word_t  pos_r   [AXIS_COUNT];
  word_t  rem_r   [AXIS_COUNT];
  word_t  acc_r   [AXIS_COUNT];
  word_t  inc_r   [AXIS_COUNT];
  logic   app_r   [AXIS_COUNT];
  logic   req_r   [AXIS_COUNT];
  ticks_t low_r   [AXIS_COUNT];
  ticks_t hold_r  [AXIS_COUNT];
  ticks_t setup_r [AXIS_COUNT];
  logic   pend_r  [AXIS_COUNT];
  pins_t  step_pin_r;
  pins_t  dir_pin_r;

  word_t  pos_nxt   [AXIS_COUNT];
  word_t  rem_nxt   [AXIS_COUNT];
  word_t  acc_nxt   [AXIS_COUNT];
  word_t  inc_nxt   [AXIS_COUNT];
  logic   app_nxt   [AXIS_COUNT];
  logic   req_nxt   [AXIS_COUNT];
  ticks_t low_nxt   [AXIS_COUNT];
  ticks_t hold_nxt  [AXIS_COUNT];
  ticks_t setup_nxt [AXIS_COUNT];
  logic   pend_nxt  [AXIS_COUNT];
  pins_t  step_pin_nxt;
  pins_t  dir_pin_nxt;

  // per-axis tick outcomes, padded so the pin fields can always be indexed
  logic   issue_ext  [ExtCount];
  logic   dapply_ext [ExtCount];
  logic   dval_ext   [ExtCount];

  always_comb begin
    logic        lb;
    logic        hb;
    logic        sb;
    logic        free;
    logic [32:0] sum;
    logic [32:0] diff;
    logic [32:0] ndiff;
    logic        neg;
    word_t       mag;

    lb    = 1'b0;
    hb    = 1'b0;
    sb    = 1'b0;
    free  = 1'b0;
    sum   = '0;
    diff  = '0;
    ndiff = '0;
    neg   = 1'b0;
    mag   = '0;

    for (int i = 0; i < AXIS_COUNT; i++) begin
      pos_nxt[i]   = pos_r[i];
      rem_nxt[i]   = rem_r[i];
      acc_nxt[i]   = acc_r[i];
      inc_nxt[i]   = inc_r[i];
      app_nxt[i]   = app_r[i];
      req_nxt[i]   = req_r[i];
      low_nxt[i]   = low_r[i];
      hold_nxt[i]  = hold_r[i];
      setup_nxt[i] = setup_r[i];
      pend_nxt[i]  = pend_r[i];
    end
    for (int i = 0; i < ExtCount; i++) begin
      issue_ext[i]  = 1'b0;
      dapply_ext[i] = 1'b0;
      dval_ext[i]   = 1'b0;
    end
    step_pin_nxt = step_pin_r;
    dir_pin_nxt  = dir_pin_r;

    if (advance) begin
      case (s1_cmd_r)
        CMD_TICK: begin
          for (int i = 0; i < AXIS_COUNT; i++) begin
            // blockers are judged on the counts before this tick
            lb   = (low_r[i] != 8'd0);
            hb   = (hold_r[i] != 8'd0);
            sb   = (setup_r[i] != 8'd0);
            free = !lb && !hb && !sb;
            sum  = {1'b0, acc_r[i]} + {1'b0, inc_r[i]};
            if (lb) low_nxt[i]   = low_r[i] - 8'd1;
            if (hb) hold_nxt[i]  = hold_r[i] - 8'd1;
            if (sb) setup_nxt[i] = setup_r[i] - 8'd1;

            if (req_r[i] != app_r[i]) begin
              if (!lb && !hb) begin
                app_nxt[i]    = req_r[i];
                dapply_ext[i] = 1'b1;
                dval_ext[i]   = req_r[i];
                setup_nxt[i]  = dir_setup_r;
                acc_nxt[i]    = '0;
                pend_nxt[i]   = 1'b0;
              end
            end else if (rem_r[i] == '0) begin
              pend_nxt[i] = 1'b0;
            end else if (pend_r[i]) begin
              issue_ext[i] = free;
            end else begin
              acc_nxt[i] = sum[31:0];
              if (sum[32]) begin
                if (free) issue_ext[i] = 1'b1;
                else pend_nxt[i] = 1'b1;
              end
            end

            if (issue_ext[i]) begin
              pos_nxt[i]  = app_r[i] ? (pos_r[i] - 32'd1) : (pos_r[i] + 32'd1);
              rem_nxt[i]  = rem_r[i] - 32'd1;
              pend_nxt[i] = 1'b0;
              low_nxt[i]  = step_low_r;
              hold_nxt[i] = dir_hold_r;
            end
          end
          for (int j = 0; j < PIN_W; j++) begin
            step_pin_nxt[j] = issue_ext[j];
            if (dapply_ext[j]) dir_pin_nxt[j] = dval_ext[j] ^ dir_inv_r[j];
          end
        end
        CMD_SET_TARGET: begin
          for (int i = 0; i < AXIS_COUNT; i++) begin
            if (int'(s1_axis_r) == i) begin
              diff  = {s1_target_r[31], s1_target_r} - {pos_r[i][31], pos_r[i]};
              ndiff = ~diff + 33'd1;
              neg   = diff[32];
              mag   = neg ? ndiff[31:0] : diff[31:0];
              // a real move against the requested direction restarts the phase
              if (mag != '0 && neg != req_r[i]) begin
                acc_nxt[i]  = '0;
                pend_nxt[i] = 1'b0;
              end
              req_nxt[i] = neg;
              rem_nxt[i] = mag;
              inc_nxt[i] = (mag != '0) ? s1_inc_r : '0;
              if (mag == '0) pend_nxt[i] = 1'b0;
            end
          end
        end
        CMD_STOP_ALL: begin
          for (int i = 0; i < AXIS_COUNT; i++) begin
            rem_nxt[i]   = '0;
            inc_nxt[i]   = '0;
            acc_nxt[i]   = '0;
            pend_nxt[i]  = 1'b0;
            low_nxt[i]   = '0;
            hold_nxt[i]  = '0;
            setup_nxt[i] = '0;
          end
          step_pin_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        pos_r[i]   <= '0;
        rem_r[i]   <= '0;
        acc_r[i]   <= '0;
        inc_r[i]   <= '0;
        app_r[i]   <= 1'b0;
        req_r[i]   <= 1'b0;
        low_r[i]   <= '0;
        hold_r[i]  <= '0;
        setup_r[i] <= '0;
        pend_r[i]  <= 1'b0;
      end
      step_pin_r <= '0;
      dir_pin_r  <= '0;
    end else begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        pos_r[i]   <= pos_nxt[i];
        rem_r[i]   <= rem_nxt[i];
        acc_r[i]   <= acc_nxt[i];
        inc_r[i]   <= inc_nxt[i];
        app_r[i]   <= app_nxt[i];
        req_r[i]   <= req_nxt[i];
        low_r[i]   <= low_nxt[i];
        hold_r[i]  <= hold_nxt[i];
        setup_r[i] <= setup_nxt[i];
        pend_r[i]  <= pend_nxt[i];
      end
      step_pin_r <= step_pin_nxt;
      dir_pin_r  <= dir_pin_nxt;
    end
  end

  // result fields from the updated state
  logic  busy_nxt;
  word_t pos_sel_nxt;

  always_comb begin
    busy_nxt    = 1'b0;
    pos_sel_nxt = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      if (rem_nxt[i] != '0 || pend_nxt[i]) busy_nxt = 1'b1;
      if (int'(s1_axis_r) == i) pos_sel_nxt = pos_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_step_r <= act_high_r ? step_pin_nxt : ~step_pin_nxt;
      out_dir_r  <= dir_pin_nxt;
      out_pos_r  <= pos_sel_nxt;
      out_busy_r <= busy_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.step_pins = out_step_r;
  assign out_ch.dir_pins  = out_dir_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.busy_res  = out_busy_r;

  // stop all leaves nothing busy and no step asserted
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_cmd_r == CMD_STOP_ALL |=> !out_busy_r && step_pin_r == '0)
    else $error("stop all left an axis busy");

  // a pending carry on axis 0 always has distance left to cover
  a_pend_rem: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r[0] |-> rem_r[0] != '0)
    else $error("pending step without remaining distance");

  // set target and query do not touch the step pins
  a_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_cmd_r == CMD_SET_TARGET || s1_cmd_r == CMD_QUERY)
      |=> step_pin_r == $past(step_pin_r))
    else $error("step pins changed without a tick");

endmodule

// ===== bench/mdds_checker.sv =====
`timescale 1ns / 100ps
// mdds_checker: watches the command, result and register ports of the step generator,
// keeps its own copy of the axis state and compares every result transaction field by field
// depends on mdds_pkg and the channel interfaces in mdds_if.sv

module mdds_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  mdds_in_if                              in_ch,
  mdds_out_if                             out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mdds_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              mismatches,
  output int                              owed
);
  import mdds_pkg::*;

  localparam int AXES = 3;

  typedef struct packed {
    pins_t step_pins;
    pins_t dir_pins;
    word_t position;
    logic  busy;
  } pin_report_t;

  word_t  pos      [AXES];
  word_t  remain   [AXES];
  word_t  phase    [AXES];
  word_t  incr     [AXES];
  logic   app_neg  [AXES];
  logic   req_neg  [AXES];
  logic   carry    [AXES];
  ticks_t low_cd   [AXES];
  ticks_t hold_cd  [AXES];
  ticks_t setup_cd [AXES];
  pins_t  step_lvl;
  pins_t  dir_reg;

  pins_t  inv_mask;
  ticks_t low_len;
  ticks_t hold_ticks;
  ticks_t setup_ticks;
  logic   act_high;

  pin_report_t owed_reports[$];
  pin_report_t want;
  int          bad = 0;

  task automatic take_command(input cmd_t c, input logic [1:0] ax, input word_t tgt,
                              input word_t inc);
    longint      delta;
    longint      dist_abs;
    logic        neg;
    logic        lb;
    logic        hb;
    logic        sb;
    logic        issue;
    logic [32:0] sum;
    word_t       mag;
    pins_t       stepped;
    pin_report_t r;
    case (c)
      CMD_TICK: begin
        stepped = '0;
        for (int i = 0; i < AXES; i++) begin
          // blockers are judged on the counts before this tick
          lb = low_cd[i] != 0;
          hb = hold_cd[i] != 0;
          sb = setup_cd[i] != 0;
          if (lb) low_cd[i] = low_cd[i] - 8'd1;
          if (hb) hold_cd[i] = hold_cd[i] - 8'd1;
          if (sb) setup_cd[i] = setup_cd[i] - 8'd1;
          if (req_neg[i] != app_neg[i]) begin
            // a reversal waits only for step-low and dir-hold
            if (!lb && !hb) begin
              app_neg[i]  = req_neg[i];
              dir_reg[i]  = req_neg[i] ^ inv_mask[i];
              setup_cd[i] = setup_ticks;
              phase[i]    = '0;
              carry[i]    = 1'b0;
            end
          end else if (remain[i] == 0) begin
            carry[i] = 1'b0;
          end else begin
            issue = 1'b0;
            if (carry[i]) begin
              issue = !lb && !hb && !sb;
            end else begin
              sum      = {1'b0, phase[i]} + {1'b0, incr[i]};
              phase[i] = sum[31:0];
              if (sum[32]) begin
                if (!lb && !hb && !sb) issue = 1'b1;
                else carry[i] = 1'b1;
              end
            end
            if (issue) begin
              stepped[i] = 1'b1;
              pos[i]     = app_neg[i] ? pos[i] - 32'd1 : pos[i] + 32'd1;
              remain[i]  = remain[i] - 32'd1;
              carry[i]   = 1'b0;
              low_cd[i]  = low_len;
              hold_cd[i] = hold_ticks;
            end
          end
        end
        step_lvl = stepped;
      end
      CMD_SET_TARGET: begin
        if (ax < AXES) begin
          delta    = longint'($signed(tgt)) - longint'($signed(pos[ax]));
          neg      = delta < 0;
          dist_abs = neg ? -delta : delta;
          mag      = dist_abs[31:0];
          if (mag != 0 && neg != req_neg[ax]) begin
            phase[ax] = '0;
            carry[ax] = 1'b0;
          end
          req_neg[ax] = neg;
          remain[ax]  = mag;
          incr[ax]    = (mag != 0) ? inc : '0;
          if (mag == 0) carry[ax] = 1'b0;
        end
      end
      CMD_STOP_ALL: begin
        for (int i = 0; i < AXES; i++) begin
          remain[i]   = '0;
          incr[i]     = '0;
          phase[i]    = '0;
          carry[i]    = 1'b0;
          low_cd[i]   = '0;
          hold_cd[i]  = '0;
          setup_cd[i] = '0;
        end
        step_lvl = '0;
      end
      default: ;
    endcase

    r.step_pins = act_high ? step_lvl : ~step_lvl;
    r.dir_pins  = dir_reg;
    r.position  = (ax < AXES) ? pos[ax] : '0;
    r.busy      = 1'b0;
    for (int i = 0; i < AXES; i++)
      if (remain[i] != 0 || carry[i]) r.busy = 1'b1;
    owed_reports.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        pos[i]      = '0;
        remain[i]   = '0;
        phase[i]    = '0;
        incr[i]     = '0;
        app_neg[i]  = 1'b0;
        req_neg[i]  = 1'b0;
        carry[i]    = 1'b0;
        low_cd[i]   = '0;
        hold_cd[i]  = '0;
        setup_cd[i] = '0;
      end
      step_lvl    = '0;
      dir_reg     = '0;
      inv_mask    = '0;
      low_len     = 8'd1;
      hold_ticks  = 8'd1;
      setup_ticks = 8'd1;
      act_high    = 1'b1;
      owed_reports.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_DIR_INVERT: inv_mask    = cfg_pwdata[2:0];
          REG_STEP_LOW:   low_len     = cfg_pwdata[7:0];
          REG_DIR_HOLD:   hold_ticks  = cfg_pwdata[7:0];
          REG_DIR_SETUP:  setup_ticks = cfg_pwdata[7:0];
          REG_ACT_HIGH:   act_high    = cfg_pwdata[0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready)
        take_command(cmd_t'(in_ch.cmd), in_ch.axis, in_ch.target, in_ch.rate_increment);

      if (out_ch.valid && out_ch.ready) begin
        if (owed_reports.size() == 0) begin
          $display("%0t: result transaction with none outstanding", $time);
          $display("%0t: got step %b dir %b pos %h busy %b", $time, out_ch.step_pins,
                   out_ch.dir_pins, out_ch.position, out_ch.busy_res);
          bad++;
        end else begin
          want = owed_reports.pop_front();
          if (out_ch.step_pins !== want.step_pins) begin
            $display("%0t: step_pins expected %b got %b", $time, want.step_pins,
                     out_ch.step_pins);
            bad++;
          end
          if (out_ch.dir_pins !== want.dir_pins) begin
            $display("%0t: dir_pins expected %b got %b", $time, want.dir_pins,
                     out_ch.dir_pins);
            bad++;
          end
          if (out_ch.position !== want.position) begin
            $display("%0t: position expected %h got %h", $time, want.position,
                     out_ch.position);
            bad++;
          end
          if (out_ch.busy_res !== want.busy) begin
            $display("%0t: busy_res expected %b got %b", $time, want.busy, out_ch.busy_res);
            bad++;
          end
        end
      end
    end
    mismatches <= bad;
    owed       <= owed_reports.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: drives commands, register writes and result back-pressure into the step generator
// depends on mdds_pkg, mdds_if.sv, the block itself and mdds_checker

module tb_top;
  import mdds_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int    mismatches;
  int    owed;
  int    cycle_count = 0;
  int    hold_asks   = 0;
  int    hold_served = 0;
  int    sink_gap    = 0;
  int    sink_calm   = 0;
  int    sink_roll;
  int    src_calm    = 0;
  word_t aim [3];

  mdds_in_if  in_ch();
  mdds_out_if out_ch();

  multi_axis_dds_step_generator_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  mdds_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .owed        (owed)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("multi_axis_dds_step_generator_top verification failed");
      $finish;
    end
  end

  // result side: random gaps, calm stretches and the requested long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (sink_gap != 0) begin
      out_ch.ready <= 1'b0;
      sink_gap     <= sink_gap - 1;
    end else if (hold_served != hold_asks) begin
      out_ch.ready <= 1'b0;
      sink_gap     <= 200;
      hold_served  <= hold_asks;
    end else begin
      out_ch.ready <= 1'b1;
      if (sink_calm != 0) begin
        sink_calm <= sink_calm - 1;
      end else begin
        sink_roll = $urandom_range(0, 99);
        if (sink_roll < 3) sink_calm <= $urandom_range(50, 300);
        else if (sink_roll < 20) sink_gap <= $urandom_range(1, 3);
        else if (sink_roll < 23) sink_gap <= $urandom_range(10, 40);
      end
    end
  end

  task automatic send_cmd(input cmd_t c, input logic [1:0] ax, input word_t tgt,
                          input word_t inc);
    int roll;
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= c;
    in_ch.axis           <= ax;
    in_ch.target         <= tgt;
    in_ch.rate_increment <= inc;
    do @(posedge clk); while (!in_ch.ready);
    gap = 0;
    if (src_calm != 0) begin
      src_calm--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 2) src_calm = $urandom_range(30, 100);
      else if (roll < 22) gap = $urandom_range(1, 3);
      else if (roll < 25) gap = $urandom_range(8, 40);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result transaction
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic set_regs(input pins_t inv, input ticks_t low, input ticks_t hold,
                          input ticks_t setup, input logic act);
    write_reg(REG_DIR_INVERT, 32'(inv));
    write_reg(REG_STEP_LOW, 32'(low));
    write_reg(REG_DIR_HOLD, 32'(hold));
    write_reg(REG_DIR_SETUP, 32'(setup));
    write_reg(REG_ACT_HIGH, 32'(act));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int         roll;
    logic [1:0] ax;
    word_t      tgt;
    word_t      inc;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      ax   = 2'($urandom_range(0, 2));
      tgt  = $urandom;
      inc  = $urandom;
      if (roll < 60) begin
        send_cmd(CMD_TICK, 2'($urandom_range(0, 3)), tgt, inc);
      end else if (roll < 80) begin
        // short move around the last short target so axes finish and reverse
        tgt = aim[ax] + $urandom_range(0, 40) - 20;
        case ($urandom_range(0, 7))
          0:       inc = '1;
          1:       inc = '0;
          2:       inc = $urandom;
          default: inc = $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
        endcase
        aim[ax] = tgt;
        send_cmd(CMD_SET_TARGET, ax, tgt, inc);
      end else if (roll < 84) begin
        send_cmd(CMD_SET_TARGET, 2'd3, tgt, inc);
      end else if (roll < 87) begin
        send_cmd(CMD_SET_TARGET, ax, tgt, inc);
      end else if (roll < 91) begin
        send_cmd(CMD_STOP_ALL, 2'($urandom_range(0, 3)), tgt, inc);
      end else begin
        send_cmd(CMD_QUERY, 2'($urandom_range(0, 3)), tgt, inc);
      end
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= CMD_QUERY;
    in_ch.axis           <= 2'd0;
    in_ch.target         <= '0;
    in_ch.rate_increment <= '0;
    cfg_psel             <= 1'b0;
    cfg_penable          <= 1'b0;
    cfg_pwrite           <= 1'b0;
    cfg_paddr            <= '0;
    cfg_pwdata           <= '0;
    foreach (aim[a]) aim[a] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, ignored axis, zero distance, full-speed moves, reversals, stop
    send_cmd(CMD_QUERY, 2'd0, '0, '0);
    send_cmd(CMD_QUERY, 2'd3, '1, '1);
    send_cmd(CMD_SET_TARGET, 2'd3, 32'd100, '1);
    send_cmd(CMD_SET_TARGET, 2'd0, '0, 32'd5);
    send_cmd(CMD_TICK, 2'd0, '0, '0);
    send_cmd(CMD_SET_TARGET, 2'd0, 32'd3, '1);
    repeat (6) send_cmd(CMD_TICK, 2'd0, '0, '0);
    send_cmd(CMD_SET_TARGET, 2'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_cmd(CMD_SET_TARGET, 2'd2, 32'h8000_0000, '1);
    repeat (4) send_cmd(CMD_TICK, 2'd2, '0, '0);
    send_cmd(CMD_SET_TARGET, 2'd0, 32'hFFFF_FFFE, '1);
    repeat (3) send_cmd(CMD_TICK, 2'd1, '1, '1);
    send_cmd(CMD_STOP_ALL, 2'd1, '0, '0);
    send_cmd(CMD_TICK, 2'd0, '0, '0);
    send_cmd(CMD_QUERY, 2'd2, '0, '0);
    drain();

    set_regs(3'd7, 8'd0, 8'd0, 8'd0, 1'b0);
    run_random(300);
    drain();

    set_regs(3'd5, 8'd255, 8'd255, 8'd255, 1'b1);
    run_random(100);
    drain();

    set_regs(3'd2, 8'd3, 8'd0, 8'd2, 1'b0);
    run_random(120);
    hold_asks++;
    run_random(180);
    drain();

    repeat (2) begin
      set_regs(3'($urandom), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
               8'($urandom_range(0, 6)), 1'($urandom));
      run_random(150);
      drain();
      run_random(150);
      drain();
    end

    set_regs(3'd0, 8'd1, 8'd1, 8'd1, 1'b1);
    run_random(300);
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("multi_axis_dds_step_generator_top verification clean");
    end else begin
      $display("multi_axis_dds_step_generator_top verification failed");
    end
    $finish;
  end

endmodule

// ===== multi_axis_dds_step_generator_top.f =====
hdl/mdds_pkg.sv
hdl/mdds_if.sv
hdl/multi_axis_dds_step_generator_top.sv
bench/mdds_checker.sv
bench/tb_top.sv
